// ===== design/ghst_pkg.sv =====
`timescale 1ns / 1ps

package ghst_pkg;

	// Request codes carried in req_type.
	localparam logic [2:0] OP_ALLOC    = 3'd0;
	localparam logic [2:0] OP_QUERY    = 3'd1;
	localparam logic [2:0] OP_TAKE     = 3'd2;
	localparam logic [2:0] OP_FREE     = 3'd3;
	localparam logic [2:0] OP_COMPLETE = 3'd4;

	// Slot states.
	localparam logic [1:0] SLOT_NONE    = 2'd0;
	localparam logic [1:0] SLOT_PENDING = 2'd1;
	localparam logic [1:0] SLOT_DONE    = 2'd2;
	localparam logic [1:0] SLOT_FAILED  = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] handle;
		logic [15:0] slot_number;
		logic [1:0]  new_state;
		logic [31:0] byte_count;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] new_handle;
		logic [1:0]  slot_state;
		logic [31:0] taken_size;
	} rsp_t;

	// One entry of the slot memory.
	typedef struct packed {
		logic [15:0] gen;
		logic [1:0]  status;
		logic [31:0] size;
	} slot_entry_t;

	// Generation bump that never lands on zero, so a zero generation is never valid.
	function automatic logic [15:0] next_gen(input logic [15:0] g);
		logic [15:0] n;
		begin
			n = g + 16'd1;
			next_gen = (n == 16'd0) ? 16'd1 : n;
		end
	endfunction

endpackage

// ===== design/ghst_slot_ram.sv =====
`timescale 1ns / 1ps

module ghst_slot_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  ghst_pkg::slot_entry_t wdata,
	input  logic [AW-1:0]        raddr,
	output ghst_pkg::slot_entry_t rdata
);
	import ghst_pkg::*;

	slot_entry_t mem [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/generational_handle_slot_table.sv =====
`timescale 1ns / 1ps

// Channel   Ports                 Direction  Handshake
// request   start, req, busy      in         item taken at a clock edge with start high, busy low
// result    done, rsp             out        one-cycle strobe on done, cannot be held off
//
// A request whose handle or slot number is out of range, an allocate with an
// empty free stack, and an unknown code are answered in the cycle after acceptance.
// Query, take, free and complete go through a slot memory read, then a write back;
// allocate first reads the free stack, since that read must land before the slot read.
// After reset a clearing pass fills both memories; busy is high meanwhile.
// The result side cannot stall, so the block never waits on its receiver.
module generational_handle_slot_table #(
	parameter int NUM_SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ghst_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output ghst_pkg::rsp_t rsp
);
	import ghst_pkg::*;

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [15:0]   NSLOT    = 16'(NUM_SLOTS);
	localparam logic [CW-1:0] TOP_FULL = CW'(NUM_SLOTS);
	localparam logic [AW-1:0] CLR_LAST = AW'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_POP, S_MOD} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] top_q;
	req_t          req_q;
	logic [15:0]   idx_q;
	logic          done_q;
	rsp_t          rsp_q;

	// The free stack holds slot numbers; top_q counts the entries in use.
	logic [15:0]   stack_mem [NUM_SLOTS];
	logic [15:0]   stk_rd_q;
	logic          stk_we;
	logic [AW-1:0] stk_waddr;
	logic [15:0]   stk_wdata;
	logic [CW-1:0] top_m1;

	// Slot memory ports.
	logic          slot_we;
	logic [AW-1:0] slot_waddr;
	slot_entry_t   slot_wdata;
	logic [AW-1:0] slot_raddr;
	slot_entry_t   slot_rdata;
	logic [15:0]   idx_m1;

	// Decode of the request at the input, used when an item is accepted.
	logic          accept;
	logic [15:0]   sel_idx;
	logic [15:0]   sel_m1;
	logic          handle_ok;
	logic          sn_ok;

	// Results of the write-back stage.
	logic          mod_we;
	slot_entry_t   mod_wdata;
	rsp_t          mod_rsp;
	logic          mod_push;
	logic          mod_pop;
	logic          gen_match;
	logic [15:0]   bumped_gen;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign accept = start && !busy;
	assign top_m1 = top_q - 1'b1;

	// A handle is structurally valid when index and generation are nonzero and
	// the index is within the table; the generation compare follows the read.
	assign handle_ok = (req.handle[15:0] != 16'd0) && (req.handle[15:0] <= NSLOT)
		&& (req.handle[31:16] != 16'd0);
	assign sn_ok = (req.slot_number != 16'd0) && (req.slot_number <= NSLOT);

	always_comb begin
		if (state_q == S_POP) begin
			sel_idx = stk_rd_q;
		end else if (req.req_type == OP_COMPLETE) begin
			sel_idx = req.slot_number;
		end else begin
			sel_idx = req.handle[15:0];
		end
	end

	assign sel_m1     = sel_idx - 16'd1;
	assign slot_raddr = sel_m1[AW-1:0];
	assign idx_m1     = idx_q - 16'd1;

	assign gen_match  = (slot_rdata.gen == req_q.handle[31:16]);
	assign bumped_gen = next_gen(slot_rdata.gen);

	// Modify step: the slot entry read in the previous cycle is updated here.
	always_comb begin
		mod_we    = 1'b0;
		mod_wdata = slot_rdata;
		mod_rsp   = '0;
		mod_push  = 1'b0;
		mod_pop   = 1'b0;
		case (req_q.req_type)
			OP_ALLOC: begin
				mod_we             = 1'b1;
				mod_wdata.gen      = bumped_gen;
				mod_wdata.status   = SLOT_PENDING;
				mod_wdata.size     = 32'd0;
				mod_pop            = 1'b1;
				mod_rsp.ok         = 1'b1;
				mod_rsp.new_handle = {bumped_gen, idx_q};
			end
			OP_QUERY: begin
				if (gen_match) begin
					mod_rsp.ok         = 1'b1;
					mod_rsp.slot_state = slot_rdata.status;
				end
			end
			OP_TAKE: begin
				if (gen_match) begin
					mod_rsp.ok = 1'b1;
					if (slot_rdata.status == SLOT_DONE) begin
						mod_rsp.taken_size = slot_rdata.size;
						mod_we             = 1'b1;
						mod_wdata.size     = 32'd0;
					end
				end
			end
			OP_FREE: begin
				if (gen_match) begin
					mod_rsp.ok       = 1'b1;
					mod_we           = 1'b1;
					mod_wdata.gen    = bumped_gen;
					mod_wdata.status = SLOT_NONE;
					mod_wdata.size   = 32'd0;
					// A push onto a full stack, as from a forged handle of a free slot, is dropped.
					mod_push         = (top_q < TOP_FULL);
				end
			end
			OP_COMPLETE: begin
				mod_rsp.ok       = 1'b1;
				mod_we           = 1'b1;
				mod_wdata.status = req_q.new_state;
				mod_wdata.size   = req_q.byte_count;
			end
			default: begin
				mod_we = 1'b0;
			end
		endcase
	end

	// Write ports: the clearing pass after reset, otherwise the modify step.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = clr_q;
		slot_wdata = '0;
		stk_we     = 1'b0;
		stk_waddr  = clr_q;
		stk_wdata  = NSLOT - 16'(clr_q);
		if (state_q == S_CLEAR) begin
			slot_we = 1'b1;
			stk_we  = 1'b1;
		end else if (state_q == S_MOD) begin
			slot_we    = mod_we;
			slot_waddr = idx_m1[AW-1:0];
			slot_wdata = mod_wdata;
			stk_we     = mod_push;
			stk_waddr  = top_q[AW-1:0];
			stk_wdata  = idx_q;
		end
	end

	ghst_slot_ram #(
		.DEPTH (NUM_SLOTS),
		.AW    (AW)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stack_mem[top_m1[AW-1:0]];
	end

	// Sequencer. Requests that fail a range check, an allocate with nothing on
	// the stack and unknown codes are answered from idle with all fields zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			top_q   <= TOP_FULL;
			req_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q <= req;
						idx_q <= sel_idx;
						rsp_q <= '0;
						case (req.req_type)
							OP_ALLOC: begin
								if (top_q != '0) begin
									state_q <= S_POP;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_QUERY, OP_TAKE, OP_FREE: begin
								if (handle_ok) begin
									state_q <= S_MOD;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_COMPLETE: begin
								if (sn_ok) begin
									state_q <= S_MOD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					// The popped slot number is now out of the stack memory.
					idx_q   <= stk_rd_q;
					state_q <= S_MOD;
				end
				S_MOD: begin
					rsp_q   <= mod_rsp;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (mod_pop) begin
						top_q <= top_m1;
					end else if (mod_push) begin
						top_q <= top_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The stack never holds more slot numbers than there are slots.
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_FULL)
		else $error("free stack count exceeds slot count");

	// Every write-back cycle is followed by exactly one result.
	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |=> (done_q && (state_q == S_IDLE)))
		else $error("write-back did not produce a result");

	// An allocate reaching the stack read always had a nonempty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (top_q != '0))
		else $error("stack popped while empty");

	// A handed-out handle never carries generation zero or slot zero.
	a_handle_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rsp_q.new_handle != 32'd0)) |->
		((rsp_q.new_handle[31:16] != 16'd0) && (rsp_q.new_handle[15:0] != 16'd0)))
		else $error("allocated handle with zero generation or index");

	// No result is produced while the memories are still being cleared.
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done_q)
		else $error("result during clearing pass");

endmodule

// ===== tb/ghst_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the slot table, keeps its own copy of the table and
// checks every result item against the answer predicted when its request was taken.
module ghst_checker #(
	parameter int NUM_SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  ghst_pkg::req_t req,
	input  logic           done,
	input  ghst_pkg::rsp_t rsp,
	output int             mismatches,
	output int             awaited
);
	import ghst_pkg::*;

	logic [15:0] stack_slots [0:NUM_SLOTS-1];
	int          stack_depth;
	logic [15:0] gen_of      [1:NUM_SLOTS];
	logic [1:0]  state_of    [1:NUM_SLOTS];
	logic [31:0] size_of     [1:NUM_SLOTS];
	rsp_t        answers_q[$];

	function automatic logic [15:0] bump_gen(input logic [15:0] g);
		return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
	endfunction

	// Slot index of a handle that still names a live generation, or 0.
	function automatic int live_slot(input logic [31:0] h);
		int idx;
		idx = int'(h[15:0]);
		if (idx == 0 || idx > NUM_SLOTS || h[31:16] == 16'd0)
			return 0;
		if (gen_of[idx] != h[31:16])
			return 0;
		return idx;
	endfunction

	task automatic clear_table();
		for (int i = 0; i < NUM_SLOTS; i++) begin
			stack_slots[i] = 16'(NUM_SLOTS - i);
			gen_of[i + 1] = 16'd0;
			state_of[i + 1] = SLOT_NONE;
			size_of[i + 1] = 32'd0;
		end
		stack_depth = NUM_SLOTS;
	endtask

	function automatic rsp_t serve_request(input req_t r);
		rsp_t o;
		int   idx;
		o = '0;
		case (r.req_type)
			OP_ALLOC: begin
				if (stack_depth > 0) begin
					idx = int'(stack_slots[stack_depth - 1]);
					if (idx != 0 && idx <= NUM_SLOTS) begin
						stack_depth--;
						gen_of[idx] = bump_gen(gen_of[idx]);
						size_of[idx] = 32'd0;
						state_of[idx] = SLOT_PENDING;
						o.ok = 1'b1;
						o.new_handle = {gen_of[idx], 16'(idx)};
					end
				end
			end
			OP_QUERY: begin
				idx = live_slot(r.handle);
				if (idx != 0) begin
					o.ok = 1'b1;
					o.slot_state = state_of[idx];
				end
			end
			OP_TAKE: begin
				idx = live_slot(r.handle);
				if (idx != 0) begin
					o.ok = 1'b1;
					if (state_of[idx] == SLOT_DONE) begin
						o.taken_size = size_of[idx];
						size_of[idx] = 32'd0;
					end
				end
			end
			OP_FREE: begin
				idx = live_slot(r.handle);
				if (idx != 0) begin
					o.ok = 1'b1;
					size_of[idx] = 32'd0;
					state_of[idx] = SLOT_NONE;
					gen_of[idx] = bump_gen(gen_of[idx]);
					// A push onto a full stack, as from a forged free of a free slot, is dropped.
					if (stack_depth < NUM_SLOTS) begin
						stack_slots[stack_depth] = 16'(idx);
						stack_depth++;
					end
				end
			end
			OP_COMPLETE: begin
				if (r.slot_number != 16'd0 && r.slot_number <= NUM_SLOTS) begin
					o.ok = 1'b1;
					state_of[r.slot_number] = r.new_state;
					size_of[r.slot_number] = r.byte_count;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			clear_table();
			answers_q.delete();
			mismatches = 0;
			awaited = 0;
		end else begin
			// A result answers an earlier request, so it is matched before a new one is taken.
			if (done) begin
				if (answers_q.size() == 0) begin
					$display("%0t: result with none awaited, actual %h", $time, rsp);
					mismatches++;
				end else begin
					want = answers_q.pop_front();
					if (want.ok !== rsp.ok)
						report("ok", 32'(want.ok), 32'(rsp.ok));
					if (want.new_handle !== rsp.new_handle)
						report("new_handle", want.new_handle, rsp.new_handle);
					if (want.slot_state !== rsp.slot_state)
						report("slot_state", 32'(want.slot_state), 32'(rsp.slot_state));
					if (want.taken_size !== rsp.taken_size)
						report("taken_size", want.taken_size, rsp.taken_size);
				end
			end
			if (start && !busy)
				answers_q.push_back(serve_request(req));
			awaited = answers_q.size();
		end
	end

endmodule

// ===== tb/tb_generational_handle_slot_table.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the generational handle slot table. The checker beside
// the block predicts and compares; this module only drives requests and decides
// pass or fail from the checker's mismatch count.
module tb_generational_handle_slot_table;
	import ghst_pkg::*;

	localparam int         NUM_SLOTS     = 16;
	localparam int         CYCLE_LIMIT   = 3_000_000;
	localparam int         RANDOM_ITEMS  = 850;
	localparam int         RANDOM_PHASES = 8;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        start;
	req_t        req;
	logic        busy;
	logic        done;
	rsp_t        rsp;
	int          mismatches;
	int          awaited;
	int          cycle_count;
	bit          idle_on;
	logic [31:0] handle_pool[$];

	generational_handle_slot_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	ghst_checker #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.mismatches(mismatches),
		.awaited(awaited)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: covers a hung handshake or a result that never comes back.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Handles given out by the block feed later requests. Only an allocate can
	// return a nonzero handle, so no bookkeeping of request types is needed here.
	// The pool is kept short so that stale entries stay a minority.
	always @(posedge clk) begin
		if (done && rsp.ok && rsp.new_handle != 32'd0) begin
			handle_pool.push_back(rsp.new_handle);
			if (handle_pool.size() > 24)
				void'(handle_pool.pop_front());
		end
	end

	function automatic req_t make_req(input logic [2:0] op, input logic [31:0] h,
			input logic [15:0] sn, input logic [1:0] st, input logic [31:0] bc);
		req_t r;
		r.req_type = op;
		r.handle = h;
		r.slot_number = sn;
		r.new_state = st;
		r.byte_count = bc;
		return r;
	endfunction

	function automatic int pick_gap();
		return idle_on ? $urandom_range(0, 16) : 0;
	endfunction

	// Random request. Most handles come from the pool (live or stale), some have
	// their generation nudged to forge a near miss, and the rest are small or wide
	// random values. Complete often targets a slot that was recently handed out,
	// so that done slots are common and take has something to return.
	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			r.req_type = OP_ALLOC;
		else if (pick < 40)
			r.req_type = OP_QUERY;
		else if (pick < 55)
			r.req_type = OP_TAKE;
		else if (pick < 75)
			r.req_type = OP_FREE;
		else if (pick < 95)
			r.req_type = OP_COMPLETE;
		else
			r.req_type = 3'($urandom_range(OP_COMPLETE + 3'd1, OP_SPARE_LAST));

		pick = $urandom_range(0, 99);
		if (pick < 70 && handle_pool.size() > 0) begin
			r.handle = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
			if ($urandom_range(0, 6) == 0)
				r.handle[31:16] = r.handle[31:16] + 16'd1;
		end else if (pick < 85) begin
			r.handle = {16'($urandom_range(0, 3)), 16'($urandom_range(0, NUM_SLOTS + 1))};
		end else begin
			r.handle = $urandom;
		end

		pick = $urandom_range(0, 99);
		if (pick < 50 && handle_pool.size() > 0)
			r.slot_number = handle_pool[$urandom_range(0, handle_pool.size() - 1)][15:0];
		else if (pick < 80)
			r.slot_number = 16'($urandom_range(1, NUM_SLOTS));
		else if (pick < 90)
			r.slot_number = $urandom_range(0, 1) ? 16'd0 : 16'(NUM_SLOTS + 1);
		else
			r.slot_number = 16'($urandom);

		r.new_state = $urandom_range(0, 1) ? SLOT_DONE : 2'($urandom);
		r.byte_count = $urandom;
		return r;
	endfunction

	// Presents one item from a falling edge and returns on the falling edge after
	// the rising edge that took it. Start stays high between back-to-back items,
	// so it is never lowered and raised within one time step.
	task automatic issue(input req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cycle_count = 0;
		idle_on = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The block answers only after its clearing pass, which the
		// busy handshake takes care of. Handles are predictable here: the free
		// stack hands out the lowest index first and every generation starts at 0.

		// Query of a slot never handed out: its generation is still zero.
		issue(make_req(OP_QUERY, {16'd1, 16'd1}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_ALLOC, 32'd0, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_FREE, {16'd1, 16'd1}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		// Forged handle of a free slot while every slot is free: the slot is
		// cleared and bumped, but the push back onto the full stack is dropped.
		issue(make_req(OP_FREE, {16'd2, 16'd1}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_QUERY, {16'd1, 16'd1}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		// Hand out every slot, then one more with the stack empty.
		repeat (NUM_SLOTS + 1)
			issue(make_req(OP_ALLOC, $urandom, 16'($urandom), 2'($urandom), $urandom),
				pick_gap());
		// Backend marks slot 3 done with the largest size; take returns it once.
		issue(make_req(OP_COMPLETE, 32'd0, 16'd3, SLOT_DONE, 32'hFFFF_FFFF), pick_gap());
		issue(make_req(OP_TAKE, {16'd1, 16'd3}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_TAKE, {16'd1, 16'd3}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_QUERY, {16'd1, 16'd3}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		// Take of a slot that is still pending gives a zero size.
		issue(make_req(OP_TAKE, {16'd1, 16'd2}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		// Complete with a slot number outside the table is ignored.
		issue(make_req(OP_COMPLETE, 32'd0, 16'd0, SLOT_FAILED, 32'd7), pick_gap());
		issue(make_req(OP_COMPLETE, 32'd0, 16'(NUM_SLOTS + 1), SLOT_FAILED, 32'd7), pick_gap());
		issue(make_req(OP_COMPLETE, 32'd0, 16'hFFFF, SLOT_DONE, 32'd0), pick_gap());
		// Handles with a zero generation or an index beyond the table.
		issue(make_req(OP_QUERY, {16'd0, 16'd5}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_TAKE, {16'hFFFF, 16'hFFFF}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		// Free a live handle, then free it again once it has gone stale.
		issue(make_req(OP_FREE, {16'd1, 16'd5}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		issue(make_req(OP_FREE, {16'd1, 16'd5}, 16'd0, SLOT_NONE, 32'd0), pick_gap());
		// Unused request codes.
		issue(make_req(OP_COMPLETE + 3'd1, $urandom, 16'd1, SLOT_DONE, $urandom), pick_gap());
		issue(make_req(OP_SPARE_LAST, $urandom, 16'd2, SLOT_DONE, $urandom), pick_gap());
		drain();

		// Random part, in phases with random gaps; every fourth phase, from the third on, has none.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_on = (phase % 4 != 2);
			repeat (RANDOM_ITEMS / RANDOM_PHASES)
				issue(random_request(), pick_gap());
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
